// ===== sv/ssws_pkg.sv =====
package ssws_pkg;

    localparam int NUM_STEPS = 8;
    localparam int STEP_W    = 3;                       // width of current_step / force_step
    localparam int CNT_W     = $clog2(NUM_STEPS);
    localparam int MODES_W   = 16;
    localparam int HOLD_W    = 16;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam logic [STEP_W-1:0] LAST_STEP   = STEP_W'(NUM_STEPS - 1);
    localparam logic [STEP_W:0]   STEP_LIMIT  = (STEP_W + 1)'(NUM_STEPS);
    localparam logic [CNT_W-1:0]  LAST_COUNT  = CNT_W'(NUM_STEPS - 1);
    localparam logic [HOLD_W-1:0] HOLD_RESET  = HOLD_W'(48);

    // clock_edge codes
    localparam logic [1:0] CLK_NONE = 2'd0;
    localparam logic [1:0] CLK_RISE = 2'd1;
    localparam logic [1:0] CLK_FALL = 2'd2;

    // step mode codes (code 3 behaves as normal)
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_SKIP   = 2'd1;
    localparam logic [1:0] MODE_JUMP   = 2'd2;

    // register indexes
    localparam logic [1:0] REG_STEP_MODES = 2'd0;
    localparam logic [1:0] REG_BACKWARD   = 2'd1;
    localparam logic [1:0] REG_HOLD_TICKS = 2'd2;

    typedef struct packed {
        logic              data_present;
        logic [1:0]        clock_edge;
        logic              reset_edge;
        logic              force_valid;
        logic [STEP_W-1:0] force_step;
        logic              direction_high;
    } in_item_t;

    typedef struct packed {
        logic [STEP_W-1:0] current_step;
        logic              gate;
        logic              step_started;
    } out_item_t;

    typedef struct packed {
        logic [MODES_W-1:0] step_modes;
        logic               backward_switch;
        logic [HOLD_W-1:0]  reset_hold_ticks;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_WALK,
        ST_OUT
    } seq_state_t;

    function automatic logic [1:0] step_mode(input logic [MODES_W-1:0] modes,
                                             input logic [STEP_W-1:0]  s);
        logic [1:0] m;
        m = modes[{s, 1'b0} +: 2];
        return m;
    endfunction

    function automatic logic [STEP_W-1:0] step_next(input logic [STEP_W-1:0] s,
                                                    input logic              backwd);
        logic [STEP_W-1:0] n;
        if (backwd) begin
            n = (s == '0) ? LAST_STEP : s - STEP_W'(1);
        end else begin
            n = (s == LAST_STEP) ? '0 : s + STEP_W'(1);
        end
        return n;
    endfunction

endpackage

// ===== sv/ssws_apb_regs.sv =====
module ssws_apb_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ssws_pkg::ADDR_W-1:0] paddr,
    input  logic [ssws_pkg::DATA_W-1:0] pwdata,
    output logic [ssws_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output ssws_pkg::cfg_t              cfg
);
    import ssws_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_STEP_MODES: cfg_next.step_modes       = pwdata[MODES_W-1:0];
                REG_BACKWARD:   cfg_next.backward_switch  = pwdata[0];
                REG_HOLD_TICKS: cfg_next.reset_hold_ticks = pwdata[HOLD_W-1:0];
                default:        cfg_next = cfg_reg;     // unmapped: dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_modes       <= '0;
            cfg_reg.backward_switch  <= 1'b0;
            cfg_reg.reset_hold_ticks <= HOLD_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_STEP_MODES: prdata = DATA_W'(cfg_reg.step_modes);
            REG_BACKWARD:   prdata = DATA_W'(cfg_reg.backward_switch);
            REG_HOLD_TICKS: prdata = DATA_W'(cfg_reg.reset_hold_ticks);
            default:        prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/step_sequencer_with_skip.sv =====
// Channel   Dir  Handshake          Payload
// s_        in   s_valid/s_ready    in_item_t  (one beat per audio sample)
// m_        out  m_valid/m_ready    out_item_t (one beat per input beat)
// apb       in   psel/penable       step_modes, backward_switch, reset_hold_ticks
//
// An input beat goes from accept through EVAL, n WALK steps and OUT into the result register, where n (0..8)
// is the number of steps the shared step/mode unit walks on a clock rise.
// The next beat is taken only after the current one has left OUT for IDLE.
// The sequencer is busy during that time; s_ready is high only in IDLE.
// A result waiting on m_ready holds the block in its output state.
// aresetn is synchronous, active low; config resets to hold ticks = 48.
module step_sequencer_with_skip (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  ssws_pkg::in_item_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output ssws_pkg::out_item_t         m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ssws_pkg::ADDR_W-1:0] paddr,
    input  logic [ssws_pkg::DATA_W-1:0] pwdata,
    output logic [ssws_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import ssws_pkg::*;

    cfg_t cfg;

    ssws_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer state
    seq_state_t        state_reg, state_next;
    in_item_t          item_reg, item_next;
    logic [STEP_W-1:0] active_reg, active_next;
    logic              rsv_valid_reg, rsv_valid_next;
    logic [STEP_W-1:0] rsv_step_reg, rsv_step_next;
    logic [HOLD_W-1:0] hold_reg, hold_next;
    logic              gate_reg, gate_next;
    logic              started_reg, started_next;
    logic              backwd_reg, backwd_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;

    // hold tick and EVAL decode
    logic              hold_idle;
    logic              hold_ended;
    logic [HOLD_W-1:0] hold_dec;
    logic              force_ok;
    logic              rsv_valid_eff;
    logic [STEP_W-1:0] rsv_step_eff;
    logic              dir_back;
    logic              need_walk;

    // shared step unit: one neighbor step and its mode per cycle
    logic [STEP_W-1:0] walk_step;
    logic              walk_stop;

    logic in_beat;
    logic out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_beat  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign hold_idle  = (hold_reg == '0);
    assign hold_dec   = hold_reg - HOLD_W'(1);
    assign hold_ended = !hold_idle && (hold_dec == '0);

    assign force_ok      = item_reg.force_valid && ({1'b0, item_reg.force_step} < STEP_LIMIT);
    assign rsv_valid_eff = force_ok ? 1'b1 : rsv_valid_reg;
    assign rsv_step_eff  = force_ok ? item_reg.force_step : rsv_step_reg;
    assign dir_back      = item_reg.direction_high || cfg.backward_switch;

    // a rise with data, no reset, no hold, nothing reserved and no jump step needs the skip walk
    assign need_walk = item_reg.data_present && !item_reg.reset_edge && hold_idle
                    && (item_reg.clock_edge == CLK_RISE) && !rsv_valid_eff
                    && (step_mode(cfg.step_modes, active_reg) != MODE_JUMP);

    assign walk_step = step_next(active_reg, backwd_reg);
    assign walk_stop = (step_mode(cfg.step_modes, walk_step) != MODE_SKIP)
                    || (count_reg == LAST_COUNT);   // at most one full lap

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_beat) state_next = ST_EVAL;
            end
            ST_EVAL: begin
                state_next = need_walk ? ST_WALK : ST_OUT;
            end
            ST_WALK: begin
                if (walk_stop) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        item_next      = item_reg;
        active_next    = active_reg;
        rsv_valid_next = rsv_valid_reg;
        rsv_step_next  = rsv_step_reg;
        hold_next      = hold_reg;
        gate_next      = gate_reg;
        started_next   = started_reg;
        backwd_next    = backwd_reg;
        count_next     = count_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_beat) item_next = s_data;
            end
            ST_EVAL: begin
                started_next = 1'b0;
                count_next   = '0;
                backwd_next  = dir_back;
                if (item_reg.data_present) begin
                    // every beat with data ticks the hold
                    hold_next = hold_idle ? '0 : hold_dec;
                    if (item_reg.reset_edge) begin
                        if (hold_idle) begin
                            gate_next      = 1'b0;
                            active_next    = '0;
                            rsv_valid_next = 1'b0;
                            hold_next      = cfg.reset_hold_ticks;
                            started_next   = 1'b1;
                        end
                    end else if (hold_idle) begin
                        rsv_valid_next = rsv_valid_eff;
                        rsv_step_next  = rsv_step_eff;
                        if (item_reg.clock_edge == CLK_RISE) begin
                            gate_next    = 1'b1;
                            started_next = 1'b1;
                            if (rsv_valid_eff) begin
                                active_next    = rsv_step_eff;
                                rsv_valid_next = 1'b0;
                            end else if (step_mode(cfg.step_modes, active_reg) == MODE_JUMP) begin
                                active_next = dir_back ? LAST_STEP : '0;
                            end
                        end else if (item_reg.clock_edge == CLK_FALL) begin
                            gate_next = 1'b0;
                        end
                    end else if (hold_ended) begin
                        gate_next = 1'b0;
                    end
                end
            end
            ST_WALK: begin
                active_next = walk_step;
                count_next  = count_reg + CNT_W'(1);
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next.current_step = active_reg;
                    m_data_next.gate         = gate_reg;
                    m_data_next.step_started = started_reg;
                end
            end
            default: begin
                m_valid_next = m_valid_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            active_reg    <= '0;
            rsv_valid_reg <= 1'b0;
            rsv_step_reg  <= '0;
            hold_reg      <= '0;
            gate_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            rsv_valid_reg <= rsv_valid_next;
            rsv_step_reg  <= rsv_step_next;
            hold_reg      <= hold_next;
            gate_reg      <= gate_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        item_reg    <= item_next;
        started_reg <= started_next;
        backwd_reg  <= backwd_next;
        count_reg   <= count_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== sv/ssws_checker.sv =====
module ssws_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input ssws_pkg::out_item_t m_data
);
    import ssws_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // one beat at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while item in flight");

    // a new result only comes out of the busy phase
    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without work");

    // idle stays ready while no beat arrives
    a_idle_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready && !s_valid |=> s_ready)
        else $error("ready dropped without an input beat");

endmodule

bind step_sequencer_with_skip ssws_checker u_ssws_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== verif/tb.sv =====
module tb;
    import ssws_pkg::*;

    // Cycles with no beat on either channel and no register access before giving up.
    // The slowest beat walks a full lap of steps, plus a receiver stall streak at 83%, so this is generous.
    localparam int WATCHDOG_LIMIT = 5000;
    // Idle cycles after the last result before a register write or the final verdict.
    localparam int SETTLE_CYCLES  = 12;

    typedef enum {HOLD_IDLE, HOLD_RUNNING, HOLD_ENDED} hold_status_e;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    in_item_t            s_data;
    logic                m_valid;
    logic                m_ready;
    out_item_t           m_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Samples waiting to go out; the head stays here until its beat is accepted.
    in_item_t            samples_to_send[$];
    // Step outputs predicted for accepted samples, oldest first.
    out_item_t           step_outs_due[$];

    // Sequencer shadow: register copies and state.
    logic [MODES_W-1:0]  cfg_modes;
    logic                cfg_backward;
    logic [HOLD_W-1:0]   cfg_hold_ticks;
    logic [STEP_W-1:0]   seq_step;
    logic                seq_res_valid;
    logic [STEP_W-1:0]   seq_res_step;
    logic [HOLD_W-1:0]   seq_hold;
    logic                seq_gate;

    int                  send_idle_pct;
    int                  recv_stall_pct;
    int                  mismatches;
    int                  quiet_cycles;

    step_sequencer_with_skip uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 aclk = ~aclk;

    // One audio sample through the sequencer: updates the shadow, returns the step output.
    function automatic out_item_t predict_sample(input in_item_t smp);
        out_item_t    res;
        hold_status_e hs;
        logic         bwd;
        logic         started;
        started = 1'b0;
        if (smp.data_present) begin
            // hold ticks on every sample with data, reset or not
            if (seq_hold == '0) begin
                hs = HOLD_IDLE;
            end else begin
                seq_hold = seq_hold - 1'b1;
                hs = (seq_hold == '0) ? HOLD_ENDED : HOLD_RUNNING;
            end
            if (smp.reset_edge) begin
                // a reset during a hold is dropped, and so are clock and force
                if (hs == HOLD_IDLE) begin
                    seq_gate      = 1'b0;
                    seq_step      = '0;
                    seq_res_valid = 1'b0;
                    seq_hold      = cfg_hold_ticks;
                    started       = 1'b1;
                end
            end else if (hs == HOLD_IDLE) begin
                if (smp.force_valid && int'(smp.force_step) < NUM_STEPS) begin
                    seq_res_valid = 1'b1;
                    seq_res_step  = smp.force_step;
                end
                if (smp.clock_edge == CLK_RISE) begin
                    bwd = smp.direction_high || cfg_backward;
                    if (seq_res_valid) begin
                        seq_step      = seq_res_step;
                        seq_res_valid = 1'b0;
                    end else if (cfg_modes[2*int'(seq_step) +: 2] == MODE_JUMP) begin
                        seq_step = bwd ? LAST_STEP : '0;
                    end else begin
                        // walk with wrap over skip steps, one lap at most
                        for (int k = 0; k < NUM_STEPS; k++) begin
                            if (bwd) begin
                                seq_step = (seq_step == '0) ? LAST_STEP : seq_step - 1'b1;
                            end else begin
                                seq_step = (seq_step == LAST_STEP) ? '0 : seq_step + 1'b1;
                            end
                            if (cfg_modes[2*int'(seq_step) +: 2] != MODE_SKIP) break;
                        end
                    end
                    seq_gate = 1'b1;
                    started  = 1'b1;
                end else if (smp.clock_edge == CLK_FALL) begin
                    seq_gate = 1'b0;
                end
            end else if (hs == HOLD_ENDED) begin
                seq_gate = 1'b0;
            end
        end
        res.current_step = seq_step;
        res.gate         = seq_gate;
        res.step_started = started;
        return res;
    endfunction

    function automatic in_item_t sample_of(input logic dp, input logic [1:0] ce,
                                           input logic rst, input logic fv,
                                           input logic [STEP_W-1:0] fs, input logic dir);
        in_item_t smp;
        smp.data_present   = dp;
        smp.clock_edge     = ce;
        smp.reset_edge     = rst;
        smp.force_valid    = fv;
        smp.force_step     = fs;
        smp.direction_high = dir;
        return smp;
    endfunction

    // Driver: a beat stays on the bus unchanged until accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                step_outs_due.push_back(predict_sample(s_data));
                void'(samples_to_send.pop_front());
            end
            if (s_valid && !s_ready) begin
                // still waiting on the block
            end else if (samples_to_send.size() != 0 &&
                         $urandom_range(0, 99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= samples_to_send[0];
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: every result beat is matched against the oldest prediction.
    always @(posedge aclk) begin
        out_item_t due;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (step_outs_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch %0d: result beat with nothing due, got step %0d gate %0b start %0b",
                                 mismatches, m_data.current_step, m_data.gate,
                                 m_data.step_started);
                end else begin
                    due = step_outs_due.pop_front();
                    if (m_data.current_step !== due.current_step || m_data.gate !== due.gate ||
                        m_data.step_started !== due.step_started) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch %0d: expected step %0d gate %0b start %0b, got step %0d gate %0b start %0b",
                                     mismatches, due.current_step, due.gate, due.step_started,
                                     m_data.current_step, m_data.gate, m_data.step_started);
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: any beat or register access restarts the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    // APB write: setup, then access; the register takes the value at the access edge.
    task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_STEP_MODES: cfg_modes      = val[MODES_W-1:0];
            REG_BACKWARD:   cfg_backward   = val[0];
            REG_HOLD_TICKS: cfg_hold_ticks = val[HOLD_W-1:0];
            default: ;
        endcase
    endtask

    // Block is idle once every sample went out and every step output came back.
    task automatic wait_drained();
        do @(posedge aclk);
        while (samples_to_send.size() != 0 || step_outs_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Mostly alternating clock rises and falls with random content, some noise on top.
    task automatic queue_random(input int n, input int reset_pct);
        in_item_t smp;
        logic     rise_next;
        int       roll;
        rise_next = 1'b1;
        for (int i = 0; i < n; i++) begin
            smp.data_present = ($urandom_range(0, 19) != 0);
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                smp.clock_edge = rise_next ? CLK_RISE : CLK_FALL;
                rise_next = !rise_next;
            end else if (roll < 90) begin
                smp.clock_edge = CLK_NONE;
            end else begin
                smp.clock_edge = 2'($urandom_range(0, 3));
            end
            smp.reset_edge     = ($urandom_range(0, 99) < reset_pct);
            smp.force_valid    = ($urandom_range(0, 9) == 0);
            smp.force_step     = STEP_W'($urandom_range(0, NUM_STEPS - 1));
            smp.direction_high = ($urandom_range(0, 3) == 0);
            samples_to_send.push_back(smp);
        end
    endtask

    task automatic setup_phase(input logic [MODES_W-1:0] modes, input logic bwd,
                               input logic [HOLD_W-1:0] hold, input int idle_pct,
                               input int stall_pct);
        wait_drained();
        reg_write(REG_STEP_MODES, DATA_W'(modes));
        reg_write(REG_BACKWARD, DATA_W'(bwd));
        reg_write(REG_HOLD_TICKS, DATA_W'(hold));
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        m_ready        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;
        quiet_cycles   = 0;
        cfg_modes      = '0;
        cfg_backward   = 1'b0;
        cfg_hold_ticks = HOLD_RESET;
        seq_step       = '0;
        seq_res_valid  = 1'b0;
        seq_res_step   = '0;
        seq_hold       = '0;
        seq_gate       = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: step 1, 2, 6 skip, step 4 jump, step 5 mode code 3, short hold.
        setup_phase(16'h1E14, 1'b0, 16'd2, 0, 0);
        samples_to_send.push_back(sample_of(1'b0, CLK_RISE, 1'b1, 1'b1, 3'd7, 1'b1)); // no data
        samples_to_send.push_back(sample_of(1'b1, CLK_RISE, 1'b0, 1'b0, 3'd0, 1'b0)); // skips 1, 2
        samples_to_send.push_back(sample_of(1'b1, CLK_FALL, 1'b0, 1'b0, 3'd0, 1'b0));
        samples_to_send.push_back(sample_of(1'b1, CLK_RISE, 1'b0, 1'b0, 3'd0, 1'b0)); // onto jump
        samples_to_send.push_back(sample_of(1'b1, CLK_FALL, 1'b0, 1'b0, 3'd0, 1'b0));
        samples_to_send.push_back(sample_of(1'b1, CLK_RISE, 1'b0, 1'b0, 3'd0, 1'b0)); // jump fwd
        samples_to_send.push_back(sample_of(1'b1, CLK_RISE, 1'b0, 1'b0, 3'd0, 1'b1)); // wrap back
        samples_to_send.push_back(sample_of(1'b1, 2'd3,     1'b0, 1'b0, 3'd0, 1'b0)); // code 3
        samples_to_send.push_back(sample_of(1'b1, CLK_NONE, 1'b0, 1'b1, 3'd5, 1'b0)); // reserve
        samples_to_send.push_back(sample_of(1'b1, CLK_RISE, 1'b0, 1'b0, 3'd0, 1'b0)); // take it
        samples_to_send.push_back(sample_of(1'b1, CLK_RISE, 1'b0, 1'b1, 3'd2, 1'b1)); // force+rise
        samples_to_send.push_back(sample_of(1'b1, CLK_RISE, 1'b0, 1'b0, 3'd0, 1'b1)); // back, skip
        samples_to_send.push_back(sample_of(1'b1, CLK_RISE, 1'b1, 1'b1, 3'd6, 1'b0)); // reset
        samples_to_send.push_back(sample_of(1'b1, CLK_RISE, 1'b0, 1'b1, 3'd3, 1'b0)); // held
        samples_to_send.push_back(sample_of(1'b1, CLK_RISE, 1'b1, 1'b0, 3'd0, 1'b0)); // rejected
        samples_to_send.push_back(sample_of(1'b1, CLK_RISE, 1'b0, 1'b0, 3'd0, 1'b0));
        samples_to_send.push_back(sample_of(1'b1, CLK_RISE, 1'b1, 1'b0, 3'd0, 1'b0)); // reset
        samples_to_send.push_back(sample_of(1'b1, CLK_FALL, 1'b0, 1'b1, 3'd7, 1'b0)); // held
        samples_to_send.push_back(sample_of(1'b1, CLK_NONE, 1'b0, 1'b0, 3'd0, 1'b0)); // hold ends
        samples_to_send.push_back(sample_of(1'b1, CLK_RISE, 1'b0, 1'b0, 3'd0, 1'b0));

        // Directed: every step skip, panel switch backward, zero hold.
        setup_phase(16'h5555, 1'b1, 16'd0, 0, 0);
        samples_to_send.push_back(sample_of(1'b1, CLK_RISE, 1'b0, 1'b0, 3'd0, 1'b0)); // full lap
        samples_to_send.push_back(sample_of(1'b1, CLK_RISE, 1'b1, 1'b0, 3'd0, 1'b0)); // reset
        samples_to_send.push_back(sample_of(1'b1, CLK_RISE, 1'b0, 1'b0, 3'd0, 1'b1)); // no hold
        samples_to_send.push_back(sample_of(1'b1, CLK_FALL, 1'b0, 1'b1, 3'd0, 1'b1));

        // Random phases, each with its own register setting and idling.
        setup_phase(16'($urandom), 1'b0, 16'd3, 0, 0);
        queue_random(100, 4);
        setup_phase(16'hFFFF, 1'b1, 16'd0, 83, 0);
        queue_random(100, 6);
        setup_phase(16'hAAAA, 1'b0, 16'd1, 0, 83);
        queue_random(100, 5);
        setup_phase(16'h5555, 1'b1, 16'd5, 20, 20);
        queue_random(100, 4);
        setup_phase(16'($urandom), 1'b0, 16'($urandom_range(0, 20)), 0, 0);
        queue_random(60, 4);
        // sender sits out until every due step output has come back
        wait_drained();
        queue_random(60, 4);
        setup_phase(16'($urandom), 1'b1, 16'($urandom_range(2, 12)), 20, 20);
        queue_random(100, 3);
        // Longest hold last: after this reset nothing moves for the rest of the run.
        setup_phase(16'h0000, 1'b0, 16'hFFFF, 20, 20);
        queue_random(80, 0);
        samples_to_send.push_back(sample_of(1'b1, CLK_RISE, 1'b1, 1'b0, 3'd0, 1'b0));
        queue_random(20, 30);

        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && step_outs_due.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ssws_pkg.sv
sv/ssws_apb_regs.sv
sv/step_sequencer_with_skip.sv
sv/ssws_checker.sv
verif/tb.sv
